// File: rtl/core/imu_sfd_pkg.sv
// Types and constants for the serial IMU frame decoder.
// No dependencies; used by all but the stream interface.
`default_nettype none

package imu_sfd_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_FIRST = 8'h50;
    localparam logic [7:0] TYPE_LAST  = 8'h58;

    localparam int unsigned FRAME_BYTES = 9;
    localparam int unsigned WORDS       = 3;
    localparam logic [3:0]  CNT_LAST    = 4'd10;

    localparam logic [3:0] KIND_TIME     = 4'd0;
    localparam logic [3:0] KIND_ACCEL    = 4'd1;
    localparam logic [3:0] KIND_RATE     = 4'd2;
    localparam logic [3:0] KIND_ANGLE    = 4'd3;
    localparam logic [3:0] KIND_MAG      = 4'd4;

    // ceil(49/40 * 2^24): exact for magnitudes up to 2^15
    localparam logic [24:0] ACCEL_RECIP = 25'd20552090;
    localparam int unsigned ACCEL_SHIFT = 24;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [3:0]         frame_kind;
        logic [63:0]        payload;
        logic signed [19:0] scaled_x;
        logic signed [19:0] scaled_y;
        logic signed [19:0] scaled_z;
    } frame_item_t;

    typedef struct packed {
        logic last_byte;
        logic type_ok;
    } asm_status_t;

endpackage

`default_nettype wire

// File: rtl/core/imu_sfd_stream_if.sv
// Valid/ready stream interface for the serial IMU frame decoder.
// Payload type is a parameter; no other dependencies.
`default_nettype none

interface imu_sfd_stream_if #(
    parameter type data_t = logic [7:0]
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/imu_sfd_assembler.sv
// Header sync, byte counter and frame byte store.
// Depends on imu_sfd_pkg.
`default_nettype none

module imu_sfd_assembler (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      take,
    input  wire logic [7:0]                rx_byte,
    output imu_sfd_pkg::asm_status_t       status,
    output logic [3:0]                     kind,
    output logic [63:0]                    payload,
    output logic signed [15:0]             words [imu_sfd_pkg::WORDS]
);

    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic [3:0] cnt_eff;
    logic       wr_en;
    logic [3:0] wr_idx;
    logic [7:0] frame_reg [imu_sfd_pkg::FRAME_BYTES];

    // counts above the last byte cannot arise; treat as idle
    assign cnt_eff = (count_reg > imu_sfd_pkg::CNT_LAST) ? 4'd0 : count_reg;

    always_comb
    begin
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_idx     = cnt_eff - 4'd1;
        if (take)
        begin
            if (cnt_eff == 4'd0)
            begin
                count_next = (rx_byte == imu_sfd_pkg::HDR_BYTE) ? 4'd1 : 4'd0;
            end
            else if (cnt_eff < imu_sfd_pkg::CNT_LAST)
            begin
                wr_en      = 1'b1;
                count_next = cnt_eff + 4'd1;
            end
            else
            begin
                count_next = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < imu_sfd_pkg::FRAME_BYTES; i++)
        begin
            if (wr_en && (wr_idx == 4'(i)))
            begin
                frame_reg[i] <= rx_byte;
            end
        end
    end

    assign status.last_byte = (cnt_eff == imu_sfd_pkg::CNT_LAST);
    assign status.type_ok   = frame_reg[0] inside
                              {[imu_sfd_pkg::TYPE_FIRST:imu_sfd_pkg::TYPE_LAST]};

    assign kind = 4'(frame_reg[0] - imu_sfd_pkg::TYPE_FIRST);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            payload[8*i +: 8] = frame_reg[i + 1];
        end
        for (int k = 0; k < imu_sfd_pkg::WORDS; k++)
        begin
            words[k] = {frame_reg[2*k + 2], frame_reg[2*k + 1]};
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/imu_sfd_scale.sv
// Per-kind scaling of one signed 16-bit word, truncated toward zero.
// Depends on imu_sfd_pkg.
`default_nettype none

module imu_sfd_scale (
    input  wire logic [3:0]          kind,
    input  wire logic signed [15:0]  word,
    output logic signed [19:0]       scaled
);

    logic        neg;
    logic [15:0] mag;
    logic [40:0] accel_prod;
    logic [21:0] rate_prod;
    logic [21:0] angle_prod;
    logic [19:0] res_mag;

    assign neg = word[15];
    assign mag = neg ? 16'(-word) : 16'(word);

    assign accel_prod = 41'(mag) * 41'(imu_sfd_pkg::ACCEL_RECIP);
    assign rate_prod  = 22'(mag) * 22'd125;
    assign angle_prod = 22'(mag) * 22'd45;

    always_comb
    begin
        res_mag = 20'd0;
        case (kind)
            imu_sfd_pkg::KIND_ACCEL: res_mag = 20'(accel_prod >> imu_sfd_pkg::ACCEL_SHIFT);
            imu_sfd_pkg::KIND_RATE:  res_mag = 20'(rate_prod >> 3);
            imu_sfd_pkg::KIND_ANGLE: res_mag = 20'(angle_prod >> 5);
            default:                 res_mag = 20'd0;
        endcase
    end

    always_comb
    begin
        if (kind == imu_sfd_pkg::KIND_MAG)
        begin
            scaled = 20'(word);
        end
        else if (neg)
        begin
            scaled = -$signed(res_mag);
        end
        else
        begin
            scaled = $signed(res_mag);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/imu_serial_frame_decoder_core.sv
// Serial IMU frame decoder, top level.
// Depends on imu_sfd_pkg, imu_sfd_stream_if, imu_sfd_assembler, imu_sfd_scale.
//
// rx carries one received serial byte per transfer. Bytes are dropped until
// the header 0x55; the next ten bytes form the frame (type, eight payload
// bytes, trailing byte, no checksum test). On the trailing byte of a frame
// whose type is 0x50..0x58 one transfer appears on res: kind, raw payload
// and three scaled words. Other types give nothing.
// A byte is taken every cycle that rx is valid and rx.ready is high. The result
// is registered and appears on res the cycle after its trailing byte is taken;
// the scaling multipliers sit between the frame store and the result register.
// While a result waits on res, rx keeps taking bytes; only a trailing byte
// that would produce a new result is held off until res is free.
// Reset clears the byte counter and the result valid; the frame store is not
// cleared and is always written before it is read.
`default_nettype none

module imu_serial_frame_decoder_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    imu_sfd_stream_if.sink   rx,
    imu_sfd_stream_if.source res
);

    imu_sfd_pkg::asm_status_t  status;
    imu_sfd_pkg::frame_item_t  res_reg;
    imu_sfd_pkg::frame_item_t  res_next;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    logic                      take;
    logic                      emit;
    logic [3:0]                kind;
    logic [63:0]               payload;
    logic signed [15:0]        words  [imu_sfd_pkg::WORDS];
    logic signed [19:0]        scaled [imu_sfd_pkg::WORDS];

    assign rx.ready = !(status.last_byte && status.type_ok) || !res_valid_reg || res.ready;
    assign take     = rx.valid && rx.ready;
    assign emit     = take && status.last_byte && status.type_ok;

    imu_sfd_assembler u_assembler (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx.data.rx_byte),
        .status  (status),
        .kind    (kind),
        .payload (payload),
        .words   (words)
    );

    for (genvar k = 0; k < imu_sfd_pkg::WORDS; k++)
    begin : g_scale
        imu_sfd_scale u_scale (
            .kind   (kind),
            .word   (words[k]),
            .scaled (scaled[k])
        );
    end

    always_comb
    begin
        res_next            = res_reg;
        res_valid_next      = res_valid_reg;
        if (emit)
        begin
            res_valid_next      = 1'b1;
            res_next.frame_kind = kind;
            res_next.payload    = payload;
            res_next.scaled_x   = scaled[0];
            res_next.scaled_y   = scaled[1];
            res_next.scaled_z   = scaled[2];
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

endmodule

`default_nettype wire
